// File: hw/rtl/rotation_matrix_to_quaternion_top_defines.svh
// Assertion macros for the checker file.
`ifndef ROTATION_MATRIX_TO_QUATERNION_TOP_DEFINES_SVH
`define ROTATION_MATRIX_TO_QUATERNION_TOP_DEFINES_SVH

// Same-cycle implication, masked during reset.
`define RMQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rmq assertion failed");

// Next-cycle implication, masked during reset.
`define RMQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rmq assertion failed");

`endif

// File: hw/rtl/rmq_pkg.sv
package rmq_pkg;

    // Default fraction bits, 1.0 = 2^FRAC_BITS
    localparam int FRAC_BITS_DEF = 14;
    // Matrix entry and quaternion component width
    localparam int ELEM_W = 16;
    // Magnitude of a sum or difference of two entries
    localparam int MAG_W = ELEM_W + 1;

    // Which quaternion component is the large one
    typedef enum logic [1:0] {
        BR_X = 2'd0,
        BR_Y = 2'd1,
        BR_Z = 2'd2,
        BR_W = 2'd3
    } t_branch;

endpackage

// File: hw/rtl/rmq_ifs.sv
// Matrix input channel
interface rmq_mat_if;
    logic              valid;
    logic              ready;
    logic signed [15:0] elem_r1_c1;
    logic signed [15:0] elem_r1_c2;
    logic signed [15:0] elem_r1_c3;
    logic signed [15:0] elem_r2_c1;
    logic signed [15:0] elem_r2_c2;
    logic signed [15:0] elem_r2_c3;
    logic signed [15:0] elem_r3_c1;
    logic signed [15:0] elem_r3_c2;
    logic signed [15:0] elem_r3_c3;

    modport source (
        output valid, elem_r1_c1, elem_r1_c2, elem_r1_c3, elem_r2_c1, elem_r2_c2,
               elem_r2_c3, elem_r3_c1, elem_r3_c2, elem_r3_c3,
        input  ready
    );
    modport sink (
        input  valid, elem_r1_c1, elem_r1_c2, elem_r1_c3, elem_r2_c1, elem_r2_c2,
               elem_r2_c3, elem_r3_c1, elem_r3_c2, elem_r3_c3,
        output ready
    );
endinterface

// Quaternion output channel
interface rmq_quat_if;
    logic              valid;
    logic              ready;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;

    modport source (output valid, quat_x, quat_y, quat_z, quat_w, input ready);
    modport sink (input valid, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

// File: hw/rtl/rmq_front.sv
module rmq_front #(
    parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF,
    parameter int AW        = FRAC_BITS + 18
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    rmq_mat_if.sink                     i_mat,
    output logic                        o_vld,
    output logic [AW-1:0]               o_arg,
    output rmq_pkg::t_branch            o_sel,
    output logic [2:0]                  o_sgn,
    output logic [rmq_pkg::MAG_W-1:0]   o_mag [3]
);

    localparam int MW = rmq_pkg::MAG_W;

    logic signed [AW:0]   e11, e22, e33, one_w, n_arg_s;
    logic signed [17:0]   tr;
    logic signed [MW-1:0] dn [3];
    rmq_pkg::t_branch     n_sel;

    logic                 r_vld;
    logic [AW-1:0]        r_arg;
    rmq_pkg::t_branch     r_sel;
    logic [2:0]           r_sgn;
    logic [MW-1:0]        r_mag [3];

    assign i_mat.ready = i_en;

    assign e11   = (AW+1)'(i_mat.elem_r1_c1);
    assign e22   = (AW+1)'(i_mat.elem_r2_c2);
    assign e33   = (AW+1)'(i_mat.elem_r3_c3);
    assign one_w = (AW+1)'(1) <<< FRAC_BITS;
    assign tr    = 18'(i_mat.elem_r1_c1) + 18'(i_mat.elem_r2_c2) + 18'(i_mat.elem_r3_c3);

    // Branch select, radicand and the three numerators
    always_comb begin
        if (tr > 18'sd0) begin
            n_sel   = rmq_pkg::BR_W;
            n_arg_s = one_w + e11 + e22 + e33;
            dn[0]   = MW'(i_mat.elem_r3_c2) - MW'(i_mat.elem_r2_c3);
            dn[1]   = MW'(i_mat.elem_r1_c3) - MW'(i_mat.elem_r3_c1);
            dn[2]   = MW'(i_mat.elem_r2_c1) - MW'(i_mat.elem_r1_c2);
        end else if (i_mat.elem_r1_c1 > i_mat.elem_r2_c2 &&
                     i_mat.elem_r1_c1 > i_mat.elem_r3_c3) begin
            n_sel   = rmq_pkg::BR_X;
            n_arg_s = one_w + e11 - e22 - e33;
            dn[0]   = MW'(i_mat.elem_r1_c2) + MW'(i_mat.elem_r2_c1);
            dn[1]   = MW'(i_mat.elem_r1_c3) + MW'(i_mat.elem_r3_c1);
            dn[2]   = MW'(i_mat.elem_r3_c2) - MW'(i_mat.elem_r2_c3);
        end else if (i_mat.elem_r2_c2 > i_mat.elem_r3_c3) begin
            n_sel   = rmq_pkg::BR_Y;
            n_arg_s = one_w + e22 - e11 - e33;
            dn[0]   = MW'(i_mat.elem_r1_c2) + MW'(i_mat.elem_r2_c1);
            dn[1]   = MW'(i_mat.elem_r2_c3) + MW'(i_mat.elem_r3_c2);
            dn[2]   = MW'(i_mat.elem_r1_c3) - MW'(i_mat.elem_r3_c1);
        end else begin
            n_sel   = rmq_pkg::BR_Z;
            n_arg_s = one_w + e33 - e11 - e22;
            dn[0]   = MW'(i_mat.elem_r1_c3) + MW'(i_mat.elem_r3_c1);
            dn[1]   = MW'(i_mat.elem_r2_c3) + MW'(i_mat.elem_r3_c2);
            dn[2]   = MW'(i_mat.elem_r2_c1) - MW'(i_mat.elem_r1_c2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_mat.valid;
        end
    end

    // Negative radicand clamps to zero; numerators go sign-magnitude
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_arg <= n_arg_s[AW] ? '0 : n_arg_s[AW-1:0];
            r_sel <= n_sel;
            for (int k = 0; k < 3; k++) begin
                r_sgn[k] <= dn[k][MW-1];
                r_mag[k] <= dn[k][MW-1] ? MW'(-dn[k]) : MW'(dn[k]);
            end
        end
    end

    assign o_vld = r_vld;
    assign o_arg = r_arg;
    assign o_sel = r_sel;
    assign o_sgn = r_sgn;
    assign o_mag = r_mag;

endmodule

// File: hw/rtl/rmq_sqrt.sv
module rmq_sqrt #(
    parameter int SW   = 24,
    parameter int SB_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_vld,
    input  logic [2*SW-1:0]   i_rad,
    input  logic [SB_W-1:0]   i_sb,
    output logic              o_vld,
    output logic [SW-1:0]     o_root,
    output logic [SB_W-1:0]   o_sb
);

    // Stage inputs
    logic [SW:0]     c_rem  [SW];
    logic [SW-1:0]   c_root [SW];
    logic [2*SW-1:0] c_rad  [SW];
    logic [SB_W-1:0] c_sb   [SW];
    logic            c_vld  [SW];

    // Stage registers
    logic [SW:0]     r_rem  [SW];
    logic [SW-1:0]   r_root [SW];
    logic [2*SW-1:0] r_rad  [SW];
    logic [SB_W-1:0] r_sb   [SW];
    logic            r_vld  [SW];

    // One root bit per stage, two radicand bits shifted in
    for (genvar i = 0; i < SW; i++) begin : g_st
        logic [SW+2:0] n_rem2;
        logic [SW+2:0] n_trial;
        logic          n_ge;

        if (i == 0) begin : g_first
            assign c_rem[i]  = '0;
            assign c_root[i] = '0;
            assign c_rad[i]  = i_rad;
            assign c_sb[i]   = i_sb;
            assign c_vld[i]  = i_vld;
        end else begin : g_next
            assign c_rem[i]  = r_rem[i-1];
            assign c_root[i] = r_root[i-1];
            assign c_rad[i]  = r_rad[i-1];
            assign c_sb[i]   = r_sb[i-1];
            assign c_vld[i]  = r_vld[i-1];
        end

        assign n_rem2  = {c_rem[i], c_rad[i][2*SW-1 -: 2]};
        assign n_trial = {1'b0, c_root[i], 2'b01};
        assign n_ge    = (n_rem2 >= n_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[i] <= 1'b0;
            end else if (i_en) begin
                r_vld[i] <= c_vld[i];
            end
        end

        // Remainder stays below 2*root + 1, so SW+1 bits hold it
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[i]  <= n_ge ? (SW+1)'(n_rem2 - n_trial) : (SW+1)'(n_rem2);
                r_root[i] <= {c_root[i][SW-2:0], n_ge};
                r_rad[i]  <= {c_rad[i][2*SW-3:0], 2'b00};
                r_sb[i]   <= c_sb[i];
            end
        end
    end

    assign o_vld  = r_vld[SW-1];
    assign o_root = r_root[SW-1];
    assign o_sb   = r_sb[SW-1];

endmodule

// File: hw/rtl/rmq_div.sv
module rmq_div #(
    parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF,
    parameter int SW        = 24,
    parameter int DW        = FRAC_BITS + 18,
    parameter int SB_W      = 1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_vld,
    input  logic [rmq_pkg::MAG_W-1:0]  i_mag,
    input  logic [SW-1:0]              i_div,
    input  logic [SB_W-1:0]            i_sb,
    output logic                       o_vld,
    output logic [DW-1:0]              o_quo,
    output logic [SB_W-1:0]            o_sb
);

    // Dividend with the rounding half added
    logic            r_pre_vld;
    logic [DW-1:0]   r_pre_d;
    logic [SW-1:0]   r_pre_s;
    logic [SB_W-1:0] r_pre_sb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre_vld <= 1'b0;
        end else if (i_en) begin
            r_pre_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pre_d  <= (DW'(i_mag) << FRAC_BITS) + DW'(i_div >> 1);
            r_pre_s  <= i_div;
            r_pre_sb <= i_sb;
        end
    end

    logic [SW-1:0]   c_rem [DW];
    logic [DW-1:0]   c_d   [DW];
    logic [DW-1:0]   c_q   [DW];
    logic [SW-1:0]   c_s   [DW];
    logic [SB_W-1:0] c_sb  [DW];
    logic            c_vld [DW];

    logic [SW-1:0]   r_rem [DW];
    logic [DW-1:0]   r_d   [DW];
    logic [DW-1:0]   r_q   [DW];
    logic [SW-1:0]   r_s   [DW];
    logic [SB_W-1:0] r_sb  [DW];
    logic            r_vld [DW];

    // Restoring division, one quotient bit per stage
    for (genvar i = 0; i < DW; i++) begin : g_st
        logic [SW:0] n_rem2;
        logic        n_ge;

        if (i == 0) begin : g_first
            assign c_rem[i] = '0;
            assign c_d[i]   = r_pre_d;
            assign c_q[i]   = '0;
            assign c_s[i]   = r_pre_s;
            assign c_sb[i]  = r_pre_sb;
            assign c_vld[i] = r_pre_vld;
        end else begin : g_next
            assign c_rem[i] = r_rem[i-1];
            assign c_d[i]   = r_d[i-1];
            assign c_q[i]   = r_q[i-1];
            assign c_s[i]   = r_s[i-1];
            assign c_sb[i]  = r_sb[i-1];
            assign c_vld[i] = r_vld[i-1];
        end

        assign n_rem2 = {c_rem[i], c_d[i][DW-1]};
        assign n_ge   = (n_rem2 >= {1'b0, c_s[i]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[i] <= 1'b0;
            end else if (i_en) begin
                r_vld[i] <= c_vld[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[i] <= n_ge ? SW'(n_rem2 - {1'b0, c_s[i]}) : SW'(n_rem2);
                r_d[i]   <= {c_d[i][DW-2:0], 1'b0};
                r_q[i]   <= {c_q[i][DW-2:0], n_ge};
                r_s[i]   <= c_s[i];
                r_sb[i]  <= c_sb[i];
            end
        end
    end

    assign o_vld = r_vld[DW-1];
    assign o_quo = r_q[DW-1];
    assign o_sb  = r_sb[DW-1];

endmodule

// File: hw/rtl/rotation_matrix_to_quaternion_top.sv
// Channel   Dir  Payload                           Handshake
// i_mat     in   elem_r1_c1 .. elem_r3_c3 (s16)    valid/ready
// o_quat    out  quat_x, quat_y, quat_z, quat_w    valid/ready
//
// One item per cycle sustained while the output takes results. Stages in order:
// one front stage, one stage per root bit of the square root, one dividend
// stage, one stage per quotient bit, one output stage.
// Synchronous active-low reset clears the valid bits only.
// A stall at the output freezes the whole pipeline; nothing is lost or repeated.
module rotation_matrix_to_quaternion_top #(
    parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rmq_mat_if.sink    i_mat,
    rmq_quat_if.source o_quat
);

    localparam int MW = rmq_pkg::MAG_W;
    localparam int AW = FRAC_BITS + 18;
    localparam int SW = (AW + FRAC_BITS + 3) / 2;
    localparam int DW = FRAC_BITS + 18;
    localparam int PL = (FRAC_BITS >= 15) ? 32767 : (2 ** FRAC_BITS);
    localparam int NL = (FRAC_BITS >= 15) ? 32768 : (2 ** FRAC_BITS);
    localparam int SQ_SB_W = 2 + 3 + 3 * MW;
    localparam int D0_SB_W = 2 + 1 + (SW - 1) + 1;

    logic                en;
    logic                r_out_vld;
    logic signed [15:0]  r_qx, r_qy, r_qz, r_qw;

    // Whole pipeline moves unless a result is held
    assign en = !r_out_vld || o_quat.ready;

    // Front: trace, branch, radicand, numerators
    logic             f_vld;
    logic [AW-1:0]    f_arg;
    rmq_pkg::t_branch f_sel;
    logic [2:0]       f_sgn;
    logic [MW-1:0]    f_mag [3];

    rmq_front #(.FRAC_BITS(FRAC_BITS), .AW(AW)) u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_mat  (i_mat),
        .o_vld  (f_vld),
        .o_arg  (f_arg),
        .o_sel  (f_sel),
        .o_sgn  (f_sgn),
        .o_mag  (f_mag)
    );

    // Square root of arg << (FRAC_BITS + 2)
    logic               q_vld;
    logic [SW-1:0]      q_s;
    logic [SQ_SB_W-1:0] q_sb;
    logic [2*SW-1:0]    rad;

    assign rad = (2*SW)'(f_arg) << (FRAC_BITS + 2);

    rmq_sqrt #(.SW(SW), .SB_W(SQ_SB_W)) u_sqrt (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_vld  (f_vld),
        .i_rad  (rad),
        .i_sb   ({f_sel, f_sgn, f_mag[0], f_mag[1], f_mag[2]}),
        .o_vld  (q_vld),
        .o_root (q_s),
        .o_sb   (q_sb)
    );

    // Unpack sqrt sideband
    logic [1:0]    q_sel;
    logic [2:0]    q_sgn;
    logic [MW-1:0] q_mag0, q_mag1, q_mag2;
    logic [SW:0]   q_s2;
    logic [SW-2:0] q_big;

    assign {q_sel, q_sgn, q_mag0, q_mag1, q_mag2} = q_sb;
    assign q_s2  = (SW+1)'(q_s) + (SW+1)'(2);
    assign q_big = q_s2[SW:2];

    // Three dividers in parallel; lane 0 carries branch and large component
    logic               d_vld [3];
    logic [DW-1:0]      d_quo [3];
    logic [D0_SB_W-1:0] d0_sb;
    logic               d1_sb, d2_sb;

    rmq_div #(.FRAC_BITS(FRAC_BITS), .SW(SW), .DW(DW), .SB_W(D0_SB_W)) u_div0 (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_vld  (q_vld),
        .i_mag  (q_mag0),
        .i_div  (q_s),
        .i_sb   ({q_sel, (q_s == '0), q_big, q_sgn[0]}),
        .o_vld  (d_vld[0]),
        .o_quo  (d_quo[0]),
        .o_sb   (d0_sb)
    );

    rmq_div #(.FRAC_BITS(FRAC_BITS), .SW(SW), .DW(DW), .SB_W(1)) u_div1 (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_vld  (q_vld),
        .i_mag  (q_mag1),
        .i_div  (q_s),
        .i_sb   (q_sgn[1]),
        .o_vld  (d_vld[1]),
        .o_quo  (d_quo[1]),
        .o_sb   (d1_sb)
    );

    rmq_div #(.FRAC_BITS(FRAC_BITS), .SW(SW), .DW(DW), .SB_W(1)) u_div2 (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_vld  (q_vld),
        .i_mag  (q_mag2),
        .i_div  (q_s),
        .i_sb   (q_sgn[2]),
        .o_vld  (d_vld[2]),
        .o_quo  (d_quo[2]),
        .o_sb   (d2_sb)
    );

    logic [1:0]       o_sel_bits;
    rmq_pkg::t_branch o_sel;
    logic             o_zero;
    logic [SW-2:0]    o_big;
    logic             o_sgn0;

    assign {o_sel_bits, o_zero, o_big, o_sgn0} = d0_sb;
    assign o_sel = rmq_pkg::t_branch'(o_sel_bits);

    // Saturate to [-1.0, +1.0] and the 16-bit range; zero divisor gives zero
    function automatic logic signed [15:0] f_sat(input logic [DW-1:0] q, input logic neg,
                                                 input logic zero);
        logic [DW-1:0] lim;
        logic [DW-1:0] m;
        lim = neg ? DW'(NL) : DW'(PL);
        m   = (q > lim) ? lim : q;
        if (zero) begin
            return 16'sd0;
        end
        return neg ? -$signed(m[15:0]) : $signed(m[15:0]);
    endfunction

    logic signed [15:0] v0, v1, v2, vb;

    assign v0 = f_sat(d_quo[0], o_sgn0, o_zero);
    assign v1 = f_sat(d_quo[1], d1_sb, o_zero);
    assign v2 = f_sat(d_quo[2], d2_sb, o_zero);
    assign vb = f_sat(DW'(o_big), 1'b0, 1'b0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= d_vld[0];
        end
    end

    // Route lanes to components by branch
    always_ff @(posedge i_clk) begin
        if (en) begin
            case (o_sel)
                rmq_pkg::BR_X: begin
                    r_qx <= vb; r_qy <= v0; r_qz <= v1; r_qw <= v2;
                end
                rmq_pkg::BR_Y: begin
                    r_qx <= v0; r_qy <= vb; r_qz <= v1; r_qw <= v2;
                end
                rmq_pkg::BR_Z: begin
                    r_qx <= v0; r_qy <= v1; r_qz <= vb; r_qw <= v2;
                end
                default: begin
                    r_qx <= v0; r_qy <= v1; r_qz <= v2; r_qw <= vb;
                end
            endcase
        end
    end

    assign o_quat.valid  = r_out_vld;
    assign o_quat.quat_x = r_qx;
    assign o_quat.quat_y = r_qy;
    assign o_quat.quat_z = r_qz;
    assign o_quat.quat_w = r_qw;

endmodule

// File: hw/rtl/rmq_checker.sv
`include "rotation_matrix_to_quaternion_top_defines.svh"

module rmq_checker #(
    parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic signed [15:0] i_qx,
    input logic signed [15:0] i_qy,
    input logic signed [15:0] i_qz,
    input logic signed [15:0] i_qw
);

    localparam int PL = (FRAC_BITS >= 15) ? 32767 : (2 ** FRAC_BITS);
    localparam int NL = (FRAC_BITS >= 15) ? 32768 : (2 ** FRAC_BITS);

    logic [63:0] q_all;
    logic        q_in_range;

    assign q_all      = {i_qx, i_qy, i_qz, i_qw};
    assign q_in_range = (i_qx <= PL) && (i_qx >= -NL) && (i_qy <= PL) && (i_qy >= -NL) &&
                        (i_qz <= PL) && (i_qz >= -NL) && (i_qw <= PL) && (i_qw >= -NL);

    // Held result stays put until taken
    `RMQ_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)
    `RMQ_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(q_all))

    // Input backpressure only while a result is stuck
    `RMQ_ASSERT_NOW(a_in_stall, i_clk, i_rst_n, !i_in_ready, i_out_valid && !i_out_ready)

    // Every component within [-1.0, +1.0]
    `RMQ_ASSERT_NOW(a_range, i_clk, i_rst_n, i_out_valid, q_in_range)

endmodule

bind rotation_matrix_to_quaternion_top rmq_checker #(.FRAC_BITS(FRAC_BITS)) u_rmq_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_ready (i_mat.ready),
    .i_out_valid(o_quat.valid),
    .i_out_ready(o_quat.ready),
    .i_qx       (o_quat.quat_x),
    .i_qy       (o_quat.quat_y),
    .i_qz       (o_quat.quat_z),
    .i_qw       (o_quat.quat_w)
);

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps

// One expected quaternion
typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic signed [15:0] w;
} quat_t;

// Holds expected quaternions in order and checks arriving ones
class quat_scoreboard;
    quat_t pending[$];
    int    errors;

    function new();
        errors = 0;
    endfunction

    // Integer square root, floor
    static function longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // (n << FRAC) / s, rounded, halves away from zero
    static function longint div_round(longint n, longint unsigned s);
        longint unsigned mag;
        longint unsigned q;
        if (s == 0) return 0;
        mag = longint'(n < 0 ? -n : n) << 14;
        q = (mag + s / 2) / s;
        return n < 0 ? -longint'(q) : longint'(q);
    endfunction

    static function logic signed [15:0] clamp(longint v);
        if (v > 16384) v = 16384;
        if (v < -16384) v = -16384;
        return v[15:0];
    endfunction

    // Matrix -> quaternion, entries m[0..8] row-major
    function void note_matrix(logic signed [15:0] m[9]);
        longint a11, a12, a13, a21, a22, a23, a31, a32, a33;
        longint trace, rad, big, qx, qy, qz, qw;
        longint unsigned s;
        rmq_pkg::t_branch br;
        quat_t q;
        a11 = m[0]; a12 = m[1]; a13 = m[2];
        a21 = m[3]; a22 = m[4]; a23 = m[5];
        a31 = m[6]; a32 = m[7]; a33 = m[8];
        trace = a11 + a22 + a33;
        if (trace > 0) begin
            rad = trace + 16384; br = rmq_pkg::BR_W;
        end else if (a11 > a22 && a11 > a33) begin
            rad = 16384 + a11 - a22 - a33; br = rmq_pkg::BR_X;
        end else if (a22 > a33) begin
            rad = 16384 + a22 - a11 - a33; br = rmq_pkg::BR_Y;
        end else begin
            rad = 16384 + a33 - a11 - a22; br = rmq_pkg::BR_Z;
        end
        if (rad < 0) rad = 0;
        s = int_sqrt(longint'(rad) << 16);
        big = longint'((s + 2) >> 2);
        case (br)
            rmq_pkg::BR_W: begin
                qw = big; qx = div_round(a32 - a23, s);
                qy = div_round(a13 - a31, s); qz = div_round(a21 - a12, s);
            end
            rmq_pkg::BR_X: begin
                qx = big; qw = div_round(a32 - a23, s);
                qy = div_round(a12 + a21, s); qz = div_round(a13 + a31, s);
            end
            rmq_pkg::BR_Y: begin
                qy = big; qw = div_round(a13 - a31, s);
                qx = div_round(a12 + a21, s); qz = div_round(a23 + a32, s);
            end
            default: begin
                qz = big; qw = div_round(a21 - a12, s);
                qx = div_round(a13 + a31, s); qy = div_round(a23 + a32, s);
            end
        endcase
        q.x = clamp(qx); q.y = clamp(qy); q.z = clamp(qz); q.w = clamp(qw);
        pending.push_back(q);
    endfunction

    function void check_quat(quat_t got);
        quat_t exp_q;
        if (pending.size() == 0) begin
            $error("unexpected quaternion %p", got);
            errors++;
            return;
        end
        exp_q = pending.pop_front();
        if (got.x !== exp_q.x) begin
            $error("quat_x expected %0d got %0d", exp_q.x, got.x); errors++;
        end
        if (got.y !== exp_q.y) begin
            $error("quat_y expected %0d got %0d", exp_q.y, got.y); errors++;
        end
        if (got.z !== exp_q.z) begin
            $error("quat_z expected %0d got %0d", exp_q.z, got.z); errors++;
        end
        if (got.w !== exp_q.w) begin
            $error("quat_w expected %0d got %0d", exp_q.w, got.w); errors++;
        end
    endfunction
endclass

module testbench;
    localparam int LATENCY = 2 * 14 + 31;

    logic i_clk;
    logic i_rst_n;

    rmq_mat_if  mat_ch ();
    rmq_quat_if quat_ch ();

    rotation_matrix_to_quaternion_top DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_mat  (mat_ch.sink),
        .o_quat (quat_ch.source)
    );

    quat_scoreboard sb;
    int  send_idle_pct;
    int  recv_stall_pct;
    int  hold_off;      // receiver hold-off cycles left

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver: ready driven at falling edge, results taken at rising edge
    initial begin
        quat_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off > 0) begin
                hold_off--;
                quat_ch.ready <= 1'b0;
            end else begin
                quat_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && quat_ch.valid && quat_ch.ready)
            sb.check_quat({quat_ch.quat_x, quat_ch.quat_y, quat_ch.quat_z, quat_ch.quat_w});
    end

    // Offer one matrix, hold until accepted; valid stays up for the next item
    task automatic send_matrix(logic signed [15:0] m[9]);
        while ($urandom_range(99) < send_idle_pct) begin
            mat_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        mat_ch.valid <= 1'b1;
        {mat_ch.elem_r1_c1, mat_ch.elem_r1_c2, mat_ch.elem_r1_c3,
         mat_ch.elem_r2_c1, mat_ch.elem_r2_c2, mat_ch.elem_r2_c3,
         mat_ch.elem_r3_c1, mat_ch.elem_r3_c2, mat_ch.elem_r3_c3}
            <= {m[0], m[1], m[2], m[3], m[4], m[5], m[6], m[7], m[8]};
        @(posedge i_clk);
        while (!mat_ch.ready) @(posedge i_clk);
        sb.note_matrix(m);
        @(negedge i_clk);
    endtask

    // Drop valid and wait until every expected quaternion has come
    task automatic drain();
        mat_ch.valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
    endtask

    function automatic logic signed [15:0] rand_entry();
        case ($urandom_range(9))
            0: return 16'($urandom);
            1: return 16'sd16384;
            2: return -16'sd16384;
            3: return 16'sd0;
            default: return 16'($signed($urandom_range(32768)) - 16384);
        endcase
    endfunction

    // Rotation-like matrix: rotation by any angle about a random axis, one in four with small noise added
    function automatic void rand_rotation(output logic signed [15:0] m[9]);
        int c, s, axis, k;
        c = $urandom_range(32768) - 16384;
        s = ($urandom_range(1) ? 1 : -1) * $rtoi($sqrt(268435456.0 - real'(c) * c));
        axis = $urandom_range(2);
        for (k = 0; k < 9; k++) m[k] = 16'sd0;
        case (axis)
            0: begin
                m[0] = 16'sd16384; m[4] = 16'(c); m[5] = 16'(-s); m[7] = 16'(s); m[8] = 16'(c);
            end
            1: begin
                m[4] = 16'sd16384; m[0] = 16'(c); m[2] = 16'(s); m[6] = 16'(-s); m[8] = 16'(c);
            end
            default: begin
                m[8] = 16'sd16384; m[0] = 16'(c); m[1] = 16'(-s); m[3] = 16'(s); m[4] = 16'(c);
            end
        endcase
        if ($urandom_range(3) == 0)
            for (k = 0; k < 9; k++) m[k] = m[k] + 16'($signed($urandom_range(64)) - 32);
    endfunction

    task automatic run_phase(int n, int idle, int stall);
        logic signed [15:0] m[9];
        int k;
        send_idle_pct = idle;
        recv_stall_pct = stall;
        repeat (n) begin
            if ($urandom_range(99) < 70) rand_rotation(m);
            else for (k = 0; k < 9; k++) m[k] = rand_entry();
            send_matrix(m);
        end
    endtask

    initial begin
        logic signed [15:0] m[9];
        int k, i;
        sb = new();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off = 0;
        mat_ch.valid = 1'b0;
        {mat_ch.elem_r1_c1, mat_ch.elem_r1_c2, mat_ch.elem_r1_c3,
         mat_ch.elem_r2_c1, mat_ch.elem_r2_c2, mat_ch.elem_r2_c3,
         mat_ch.elem_r3_c1, mat_ch.elem_r3_c2, mat_ch.elem_r3_c3} = '0;
        i_rst_n = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: identity, each branch, ties, extremes
        m = '{16384,0,0, 0,16384,0, 0,0,16384};        send_matrix(m);
        m = '{16384,0,0, 0,-16384,0, 0,0,-16384};      send_matrix(m);
        m = '{-16384,0,0, 0,16384,0, 0,0,-16384};      send_matrix(m);
        m = '{-16384,0,0, 0,-16384,0, 0,0,16384};      send_matrix(m);
        m = '{0,0,0, 0,0,0, 0,0,0};                    send_matrix(m);
        m = '{-8192,100,-200, 300,-8192,50, 7,9,-8192}; send_matrix(m);
        m = '{-16384,0,0, 0,-16384,0, 0,0,-16384};     send_matrix(m);
        m = '{-32768,-32768,-32768, -32768,-32768,-32768, -32768,-32768,-32768};
        send_matrix(m);
        m = '{32767,32767,32767, 32767,32767,32767, 32767,32767,32767}; send_matrix(m);
        m = '{-32768,32767,-32768, 32767,-32768,32767, -32768,32767,-32768};
        send_matrix(m);
        m = '{0,-16384,0, 16384,0,0, 0,0,1};           send_matrix(m);
        m = '{0,16384,0, 16384,0,0, 0,0,-16384};       send_matrix(m);
        m = '{5,0,0, 0,5,0, 0,0,-10};                  send_matrix(m);
        m = '{-100,32767,32767, 32767,-200,32767, 32767,32767,-300}; send_matrix(m);
        m = '{-16'sh5555,16'sh5555,-16'sh2AAA, 16'sh2AAA,16'sh5555,-16'sh5555,
              16'sh7FFF,-16'sh8000,-16'sh5555};
        send_matrix(m);

        run_phase(350, 0, 0);
        run_phase(350, 57, 0);
        run_phase(350, 0, 57);
        run_phase(350, 32, 32);

        // Long receiver hold-off so the pipeline fills and input stalls
        hold_off = 3 * LATENCY;
        run_phase(100, 0, 0);
        // Sender pauses until everything has drained
        drain();
        for (i = 0; i < 8; i++) begin
            for (k = 0; k < 9; k++) m[k] = rand_entry();
            send_matrix(m);
        end
        drain();
        repeat (LATENCY + 10) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #5ms;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule
